// ===== sv/xwb_pkg.sv =====
// ----------------------------------------------------------------------------
// xwb_pkg
// Shared types and constants of the weight binariser.
// ----------------------------------------------------------------------------
package xwb_pkg;

	localparam int WEIGHT_W = 16;
	localparam int REG_W    = 13;
	localparam int ALPHA_W  = 15;

	localparam logic [ALPHA_W-1:0] ALPHA_MAX = 15'h7FFF;

	// configuration register indexes
	localparam logic [0:0] REG_FILTER_SIZE  = 1'b0;
	localparam logic [0:0] REG_FILTER_COUNT = 1'b1;

	localparam logic [REG_W-1:0] FILTER_SIZE_RST  = 13'd9;
	localparam logic [REG_W-1:0] FILTER_COUNT_RST = 13'd1;

	typedef struct packed {
		logic positive;
		logic last_of_filter;
		logic last_of_layer;
	} xwb_flags_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} xwb_back_state_t;

endpackage

// ===== sv/xwb_front.sv =====
// ----------------------------------------------------------------------------
// xwb_front
// Accepts weights, classifies sign, accumulates magnitudes and tracks the
// element and filter positions; pushes one entry per weight to the queue.
// ----------------------------------------------------------------------------
module xwb_front import xwb_pkg::*; #(
	parameter int MAX_FILTER_SIZE = 4096,
	parameter int MAX_FILTERS     = 4096,
	localparam int ZW = $clog2(MAX_FILTER_SIZE + 1),
	localparam int CZ = $clog2(MAX_FILTERS + 1),
	localparam int EW = (MAX_FILTER_SIZE > 1) ? $clog2(MAX_FILTER_SIZE) : 1,
	localparam int FW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1,
	localparam int SW = WEIGHT_W + $clog2(MAX_FILTER_SIZE)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_addr,
	input  logic [REG_W-1:0]    cfg_data,
	input  logic [WEIGHT_W-1:0] weight,
	input  logic                weight_valid,
	output logic                weight_ready,
	output logic                push,
	output xwb_flags_t          push_flags,
	output logic [SW-1:0]       push_sum,
	output logic [ZW-1:0]       push_size,
	input  logic                q_full
);

	logic [REG_W-1:0]    filter_size_q;
	logic [REG_W-1:0]    filter_count_q;
	logic [SW-1:0]       sum_q;
	logic [EW-1:0]       elem_q;
	logic [FW-1:0]       filt_q;
	logic [ZW-1:0]       size_eff;
	logic [CZ-1:0]       count_eff;
	logic [WEIGHT_W-1:0] mag;
	logic [SW-1:0]       sum_next;
	logic                end_filter;
	logic                end_layer;
	logic                accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_size_q  <= FILTER_SIZE_RST;
			filter_count_q <= FILTER_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FILTER_SIZE:  filter_size_q  <= cfg_data;
				REG_FILTER_COUNT: filter_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (filter_size_q == '0) begin
			size_eff = ZW'(1);
		end else if (32'(filter_size_q) > 32'(MAX_FILTER_SIZE)) begin
			size_eff = ZW'(MAX_FILTER_SIZE);
		end else begin
			size_eff = ZW'(filter_size_q);
		end
		if (filter_count_q == '0) begin
			count_eff = CZ'(1);
		end else if (32'(filter_count_q) > 32'(MAX_FILTERS)) begin
			count_eff = CZ'(MAX_FILTERS);
		end else begin
			count_eff = CZ'(filter_count_q);
		end
	end

	assign mag        = weight[WEIGHT_W-1] ? (~weight + WEIGHT_W'(1)) : weight;
	assign sum_next   = sum_q + SW'(mag);
	assign end_filter = (32'(elem_q) + 32'd1) >= 32'(size_eff);
	assign end_layer  = end_filter && ((32'(filt_q) + 32'd1) >= 32'(count_eff));

	assign weight_ready = !q_full;
	assign accept       = weight_valid && !q_full;

	assign push                      = accept;
	assign push_flags.positive       = !weight[WEIGHT_W-1] && (weight != '0);
	assign push_flags.last_of_filter = end_filter;
	assign push_flags.last_of_layer  = end_layer;
	assign push_sum                  = sum_next;
	assign push_size                 = size_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			elem_q <= '0;
			filt_q <= '0;
		end else if (accept) begin
			if (end_filter) begin
				sum_q  <= '0;
				elem_q <= '0;
				if (end_layer) begin
					filt_q <= '0;
				end else begin
					filt_q <= filt_q + FW'(1);
				end
			end else begin
				sum_q  <= sum_next;
				elem_q <= elem_q + EW'(1);
			end
		end
	end

endmodule

// ===== sv/xwb_queue.sv =====
// ----------------------------------------------------------------------------
// xwb_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module xwb_queue import xwb_pkg::*; #(
	parameter int DW    = 8,
	parameter int DEPTH = 4,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	output logic          full,
	output logic          valid,
	input  logic          pop,
	output logic [DW-1:0] data
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   cnt_q;

	assign full  = (32'(cnt_q) == DEPTH);
	assign valid = (cnt_q != '0);
	assign data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

endmodule

// ===== sv/xwb_back.sv =====
// ----------------------------------------------------------------------------
// xwb_back
// Drains the queue into the output register; a filter's final entry runs
// a restoring divider, one quotient bit a cycle, to form alpha.
// ----------------------------------------------------------------------------
module xwb_back import xwb_pkg::*; #(
	parameter int MAX_FILTER_SIZE = 4096,
	localparam int ZW = $clog2(MAX_FILTER_SIZE + 1),
	localparam int SW = WEIGHT_W + $clog2(MAX_FILTER_SIZE),
	localparam int NW = $clog2(SW)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  xwb_flags_t         q_flags,
	input  logic [SW-1:0]      q_sum,
	input  logic [ZW-1:0]      q_size,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               out_positive,
	output logic [ALPHA_W-1:0] out_alpha,
	output logic               out_last_of_filter,
	output logic               out_last_of_layer
);

	xwb_back_state_t    state_q;
	xwb_back_state_t    state_d;
	logic               out_valid_q;
	xwb_flags_t         out_flags_q;
	logic [ALPHA_W-1:0] out_alpha_q;
	xwb_flags_t         div_flags_q;
	logic [SW-1:0]      quo_q;
	logic [ZW-1:0]      rem_q;
	logic [ZW-1:0]      div_q;
	logic [NW-1:0]      cnt_q;
	logic [ZW:0]        trial;
	logic               take;
	logic [ZW:0]        trial_sub;
	logic [ALPHA_W-1:0] alpha_sat;
	logic               out_free;
	logic               out_load;
	logic               from_div;
	logic               div_load;
	logic               div_step;

	assign out_free  = !out_valid_q || out_ready;
	assign trial     = {rem_q, quo_q[SW-1]};
	assign take      = trial >= {1'b0, div_q};
	assign trial_sub = trial - {1'b0, div_q};
	assign alpha_sat = (quo_q > SW'(ALPHA_MAX)) ? ALPHA_MAX : quo_q[ALPHA_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid && q_flags.last_of_filter) begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (cnt_q == '0) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		pop      = 1'b0;
		out_load = 1'b0;
		from_div = 1'b0;
		div_load = 1'b0;
		div_step = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					if (q_flags.last_of_filter) begin
						pop      = 1'b1;
						div_load = 1'b1;
					end else if (out_free) begin
						pop      = 1'b1;
						out_load = 1'b1;
					end
				end
			end
			BK_DIV: div_step = 1'b1;
			BK_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					from_div = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_flags_q <= from_div ? div_flags_q : q_flags;
			out_alpha_q <= from_div ? alpha_sat : '0;
		end
		if (div_load) begin
			div_flags_q <= q_flags;
			quo_q       <= q_sum;
			div_q       <= q_size;
			rem_q       <= '0;
			cnt_q       <= NW'(SW - 1);
		end else if (div_step) begin
			quo_q <= {quo_q[SW-2:0], take};
			rem_q <= take ? trial_sub[ZW-1:0] : trial[ZW-1:0];
			cnt_q <= cnt_q - NW'(1);
		end
	end

	assign out_valid          = out_valid_q;
	assign out_positive       = out_flags_q.positive;
	assign out_alpha          = out_alpha_q;
	assign out_last_of_filter = out_flags_q.last_of_filter;
	assign out_last_of_layer  = out_flags_q.last_of_layer;

endmodule

// ===== sv/xnor_weight_binarizer.sv =====
// Path: a weight's result passes through the queue and the output register; a
// filter's final weight also passes through the 28-step bit-serial divider.
// Throughput: one word per cycle inside a filter while the queue is not full;
// each filter end holds the back part while the divider runs, so once the
// four-entry queue fills the input stalls.
// Reset: counters and running sum clear, filter_size 9, filter_count 1.
// ----------------------------------------------------------------------------
// xnor_weight_binarizer
// Weight binariser: sign bit per weight and mean absolute value per filter.
// ----------------------------------------------------------------------------
module xnor_weight_binarizer import xwb_pkg::*; #(
	parameter int MAX_FILTER_SIZE = 4096,
	parameter int MAX_FILTERS     = 4096,
	localparam int ZW = $clog2(MAX_FILTER_SIZE + 1),
	localparam int SW = WEIGHT_W + $clog2(MAX_FILTER_SIZE),
	localparam int QW = 3 + SW + ZW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_addr,
	input  logic [REG_W-1:0] cfg_data,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [15:0]      s_axis_tdata,   // weight
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // positive, alpha
	output logic             m_axis_tlast,   // last_of_filter
	output logic             m_axis_tuser    // last_of_layer
);

	logic               push;
	xwb_flags_t         push_flags;
	logic [SW-1:0]      push_sum;
	logic [ZW-1:0]      push_size;
	logic               q_full;
	logic               q_valid;
	logic               pop;
	logic [QW-1:0]      q_data;
	xwb_flags_t         q_flags;
	logic               out_positive;
	logic [ALPHA_W-1:0] out_alpha;

	xwb_front #(
		.MAX_FILTER_SIZE(MAX_FILTER_SIZE),
		.MAX_FILTERS    (MAX_FILTERS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_data    (cfg_data),
		.weight      (s_axis_tdata),
		.weight_valid(s_axis_tvalid),
		.weight_ready(s_axis_tready),
		.push        (push),
		.push_flags  (push_flags),
		.push_sum    (push_sum),
		.push_size   (push_size),
		.q_full      (q_full)
	);

	xwb_queue #(
		.DW   (QW),
		.DEPTH(4)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_flags, push_sum, push_size}),
		.full     (q_full),
		.valid    (q_valid),
		.pop      (pop),
		.data     (q_data)
	);

	assign q_flags = q_data[QW-1 -: 3];

	xwb_back #(
		.MAX_FILTER_SIZE(MAX_FILTER_SIZE)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_valid           (q_valid),
		.q_flags           (q_flags),
		.q_sum             (q_data[ZW +: SW]),
		.q_size            (q_data[ZW-1:0]),
		.pop               (pop),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.out_positive      (out_positive),
		.out_alpha         (out_alpha),
		.out_last_of_filter(m_axis_tlast),
		.out_last_of_layer (m_axis_tuser)
	);

	assign m_axis_tdata = {out_alpha, out_positive};

`ifndef SYNTH
	a_layer_ends_filter: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("layer end without filter end");

	a_alpha_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[15:1] == '0)
		else $error("alpha set inside a filter");

	a_sign_of_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tdata == '0 |-> !push_flags.positive)
		else $error("zero weight classed positive");
`endif

endmodule

// ===== bench/tb_xnor_weight_binarizer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xnor_weight_binarizer
// Streams filter weights through the binariser under random gaps on both
// sides, predicts each sign bit, filter mean and end marks in the bench, and
// compares every output word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_xnor_weight_binarizer;
	import xwb_pkg::*;

	localparam int MAX_SIZE    = 4096;
	localparam int MAX_COUNT   = 4096;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 40;

	typedef struct packed {
		logic               positive;
		logic [ALPHA_W-1:0] alpha;
		logic               last_of_filter;
		logic               last_of_layer;
	} bin_word_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [0:0]          cfg_addr = REG_FILTER_SIZE;
	logic [REG_W-1:0]    cfg_data = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [15:0]         s_axis_tdata = '0;   // weight
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [15:0]         m_axis_tdata;        // positive, alpha
	logic                m_axis_tlast;        // last_of_filter
	logic                m_axis_tuser;        // last_of_layer

	logic [15:0]         weights_pending[$];
	bin_word_t           words_due[$];

	// bench copy of the block's registers and state
	logic [REG_W-1:0]    size_reg = FILTER_SIZE_RST;
	logic [REG_W-1:0]    count_reg = FILTER_COUNT_RST;
	longint unsigned     run_abs_sum = 0;
	int unsigned         elem_pos = 0;
	int unsigned         filter_pos = 0;

	int                  n_accepted = 0;
	int                  n_fail = 0;
	int                  idle_cycles = 0;

	wire calm = (n_accepted >= 420) && (n_accepted < 580);

	xnor_weight_binarizer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #6 clk = ~clk;

	function automatic int unsigned clamp_reg(input logic [REG_W-1:0] r,
		input int unsigned lim);
		if (r == '0)
			return 1;
		if (32'(r) > lim)
			return lim;
		return 32'(r);
	endfunction

	function automatic bin_word_t binarize_weight(input logic [15:0] w);
		bin_word_t   res;
		logic [16:0] mag;
		int unsigned fsize;
		int unsigned fcount;
		longint unsigned mean;
		fsize  = clamp_reg(size_reg, MAX_SIZE);
		fcount = clamp_reg(count_reg, MAX_COUNT);
		mag = w[15] ? (17'h10000 - {1'b0, w}) : {1'b0, w};
		res = '0;
		res.positive = !w[15] && (w != 16'h0000);
		run_abs_sum += 64'(mag);
		if (elem_pos + 1 >= fsize) begin
			mean = run_abs_sum / 64'(fsize);
			res.alpha = (mean > 64'(ALPHA_MAX)) ? ALPHA_MAX : mean[ALPHA_W-1:0];
			res.last_of_filter = 1'b1;
			run_abs_sum = 0;
			elem_pos = 0;
			if (filter_pos + 1 >= fcount) begin
				res.last_of_layer = 1'b1;
				filter_pos = 0;
			end else begin
				filter_pos++;
			end
		end else begin
			elem_pos++;
		end
		return res;
	endfunction

	function automatic logic [15:0] rand_weight();
		case ($urandom_range(15))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'h0001;
			4: return 16'hFFFF;
			5: return 16'($signed(7'($urandom_range(127))));
			default: return 16'($urandom);
		endcase
	endfunction

	// weight driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				words_due.push_back(binarize_weight(s_axis_tdata));
				n_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (weights_pending.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= weights_pending.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
					s_axis_tdata  <= 16'($urandom);
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		bin_word_t got;
		bin_word_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.positive       = m_axis_tdata[0];
				got.alpha          = m_axis_tdata[15:1];
				got.last_of_filter = m_axis_tlast;
				got.last_of_layer  = m_axis_tuser;
				if (words_due.size() == 0) begin
					if (n_fail < 10)
						$display("unexpected word: pos %0b alpha %0d lf %0b ll %0b",
							got.positive, got.alpha, got.last_of_filter, got.last_of_layer);
					n_fail++;
				end else begin
					want = words_due.pop_front();
					if (got.positive !== want.positive || got.alpha !== want.alpha ||
						got.last_of_filter !== want.last_of_filter ||
						got.last_of_layer !== want.last_of_layer) begin
						if (n_fail < 10)
							$display("mismatch: exp %0b %0d %0b %0b, got %0b %0d %0b %0b",
								want.positive, want.alpha, want.last_of_filter,
								want.last_of_layer, got.positive, got.alpha,
								got.last_of_filter, got.last_of_layer);
						n_fail++;
					end
				end
			end
			m_axis_tready <= calm || ($urandom_range(99) >= 38);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("xnor_weight_binarizer verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic write_reg(input logic [0:0] idx, input logic [REG_W-1:0] val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		if (idx == REG_FILTER_SIZE)
			size_reg = val;
		else
			count_reg = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [REG_W-1:0] sz, input logic [REG_W-1:0] ct);
		if ($urandom_range(1)) begin
			write_reg(REG_FILTER_SIZE, sz);
			write_reg(REG_FILTER_COUNT, ct);
		end else begin
			write_reg(REG_FILTER_COUNT, ct);
			write_reg(REG_FILTER_SIZE, sz);
		end
		@(negedge clk);
	endtask

	// every queued word accepted and answered, then let the divider settle
	task automatic settle();
		while (weights_pending.size() != 0 || s_axis_tvalid || words_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	initial begin
		int unsigned      total;
		int unsigned      nitems;
		int unsigned      fsize;
		logic [REG_W-1:0] sz;
		logic [REG_W-1:0] ct;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: one filter of nine, zero and extremes
		weights_pending = {weights_pending, 16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
			16'h8000, 16'h0000, 16'h8000, 16'h7FFF, 16'h0002};
		settle();
		// mean of 32768 saturates, then a full-scale and a zero filter
		configure(13'd2, 13'd3);
		weights_pending = {weights_pending, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
			16'h0000, 16'h0000};
		settle();
		// zero registers act as one
		configure(13'd0, 13'd0);
		weights_pending = {weights_pending, 16'h8001, 16'h1234};
		settle();
		// oversize registers clamp, filter left open
		configure(13'h1FFF, 13'h1FFF);
		weights_pending = {weights_pending, 16'h8000, 16'h7FFF, 16'hC000};
		settle();
		// shrinking the size closes the open filter at once
		configure(13'd1, 13'd4096);
		weights_pending.push_back(16'h4000);
		settle();

		total = 0;
		while (total < 950) begin
			case ($urandom_range(19))
				0: sz = 13'd0;
				1: sz = 13'($urandom_range(4097, 8191));
				2: sz = 13'd4096;
				3: sz = 13'($urandom_range(13, 4095));
				default: sz = 13'($urandom_range(1, 12));
			endcase
			case ($urandom_range(9))
				0: ct = 13'd0;
				1: ct = 13'($urandom_range(4097, 8191));
				2: ct = 13'd4096;
				default: ct = 13'($urandom_range(1, 4));
			endcase
			configure(sz, ct);
			fsize = clamp_reg(sz, MAX_SIZE);
			if (fsize > 12)
				nitems = $urandom_range(1, 40);
			else if ($urandom_range(4) == 0)
				nitems = $urandom_range(1, 20);
			else
				nitems = fsize * $urandom_range(1, 6);
			repeat (nitems) weights_pending.push_back(rand_weight());
			total += nitems;
			settle();
		end

		n_fail += words_due.size();
		if (n_fail == 0)
			$display("xnor_weight_binarizer verification clean");
		else
			$display("xnor_weight_binarizer verification failed");
		$finish;
	end

endmodule
